/* rtl/qau_pkg.sv */
// qau_pkg: shared widths, command codes, item types and the saturation helper
// for the quaternion arithmetic unit. No dependencies.
package qau_pkg;

  // fixed point format of every value field
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;

  // derived internal widths
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int SQ_BITS   = PROD_BITS + 1;
  localparam int ROOT_BITS = WORD_BITS + 1;
  localparam int QUO_BITS  = WORD_BITS;
  localparam int NUM_BITS  = WORD_BITS + 2 * FRAC_BITS;
  localparam int REM_BITS  = SQ_BITS + QUO_BITS;
  localparam int THR_BITS  = WORD_BITS - 1;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(17);

  typedef logic signed [WORD_BITS-1:0] qword_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;

  localparam qword_t QWORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam qword_t QWORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_MUL  = 3'd0,
    CMD_ROT  = 3'd1,
    CMD_DER  = 3'd2,
    CMD_CONJ = 3'd3,
    CMD_NORM = 3'd4,
    CMD_INV  = 3'd5,
    CMD_MAG  = 3'd6
  } qau_cmd_e;

  typedef struct packed {
    logic [2:0] command;
    qword_t     a_w;
    qword_t     a_x;
    qword_t     a_y;
    qword_t     a_z;
    qword_t     b_w;
    qword_t     b_x;
    qword_t     b_y;
    qword_t     b_z;
  } qau_in_t;

  typedef struct packed {
    qword_t r_w;
    qword_t r_x;
    qword_t r_y;
    qword_t r_z;
    logic   degenerate;
    logic   saturated;
  } qau_out_t;

  // item state carried along the long root and divide pipes
  typedef struct packed {
    logic [2:0]         command;
    qword_t [3:0]       a;
    qword_t [3:0]       r;
    logic               clip;
    logic               deg;
    logic [3:0]         neg;
    logic [3:0]         ovf;
  } qau_side_t;

  typedef struct packed {
    qword_t val;
    logic   clip;
  } qau_sat_t;

  // clip a wide signed value to the word range
  function automatic qau_sat_t sat_word(input sum_t v);
    qau_sat_t res;
    sum_t     hi_lim;
    sum_t     lo_lim;
    hi_lim = SUM_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
    lo_lim = ~hi_lim;
    if (v > hi_lim) begin
      res.val  = QWORD_MAX;
      res.clip = 1'b1;
    end else if (v < lo_lim) begin
      res.val  = QWORD_MIN;
      res.clip = 1'b1;
    end else begin
      res.val  = v[WORD_BITS-1:0];
      res.clip = 1'b0;
    end
    return res;
  endfunction

endpackage

/* rtl/qau_sqrt.sv */
// qau_sqrt: pipelined integer square root, one result bit per stage, with
// item state carried alongside. Depends on qau_pkg.
module qau_sqrt
  import qau_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  qau_side_t            side_i,
  input  logic [SQ_BITS-1:0]   radicand_i,
  output logic                 valid_o,
  output qau_side_t            side_o,
  output logic [SQ_BITS-1:0]   radicand_o,
  output logic [ROOT_BITS-1:0] root_o
);

  localparam int Steps     = ROOT_BITS;
  localparam int TrialBits = SQ_BITS + 1;
  localparam int SqW       = 2 * ROOT_BITS + 1;

  logic                 valid_q [Steps];
  qau_side_t            side_q  [Steps];
  logic [SQ_BITS-1:0]   rad_q   [Steps];
  logic [SQ_BITS-1:0]   rem_q   [Steps];
  logic [ROOT_BITS-1:0] root_q  [Steps];

  logic                 cur_valid [Steps];
  qau_side_t            cur_side  [Steps];
  logic [SQ_BITS-1:0]   cur_rad   [Steps];
  logic [SQ_BITS-1:0]   cur_rem   [Steps];
  logic [ROOT_BITS-1:0] cur_root  [Steps];
  logic [TrialBits-1:0] trial     [Steps];
  logic                 take      [Steps];

  // stage inputs: the first stage sees the ports, the rest the stage before
  always_comb begin
    cur_valid[0] = valid_i;
    cur_side[0]  = side_i;
    cur_rad[0]   = radicand_i;
    cur_rem[0]   = radicand_i;
    cur_root[0]  = '0;
    for (int k = 1; k < Steps; k++) begin
      cur_valid[k] = valid_q[k-1];
      cur_side[k]  = side_q[k-1];
      cur_rad[k]   = rad_q[k-1];
      cur_rem[k]   = rem_q[k-1];
      cur_root[k]  = root_q[k-1];
    end
  end

  // trial subtract of (root + 2^b)^2 - root^2 from the remainder
  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      trial[k] = (TrialBits'(cur_root[k]) << (Steps - k))
               + (TrialBits'(1) << (2 * (Steps - 1 - k)));
      take[k]  = TrialBits'(cur_rem[k]) >= trial[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Steps; k++) valid_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < Steps; k++) valid_q[k] <= cur_valid[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Steps; k++) begin
      side_q[k] <= cur_side[k];
      rad_q[k]  <= cur_rad[k];
      if (take[k]) begin
        rem_q[k]  <= cur_rem[k] - trial[k][SQ_BITS-1:0];
        root_q[k] <= cur_root[k] | (ROOT_BITS'(1) << (Steps - 1 - k));
      end else begin
        rem_q[k]  <= cur_rem[k];
        root_q[k] <= cur_root[k];
      end
    end
  end

  assign valid_o    = valid_q[Steps-1];
  assign side_o     = side_q[Steps-1];
  assign radicand_o = rad_q[Steps-1];
  assign root_o     = root_q[Steps-1];

  // root is the floor of the square root
  a_root_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> SqW'(root_o) * SqW'(root_o) <= SqW'(radicand_o))
    else $error("root squared exceeds radicand");

  a_root_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (SqW'(root_o) + SqW'(1)) * (SqW'(root_o) + SqW'(1)) > SqW'(radicand_o))
    else $error("root too small");

endmodule

/* rtl/qau_div.sv */
// qau_div: four-lane pipelined restoring divider, one quotient bit per stage,
// sharing one divisor per item. Depends on qau_pkg.
module qau_div
  import qau_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  qau_side_t                  side_i,
  input  logic [SQ_BITS-1:0]         den_i,
  input  logic [3:0][NUM_BITS-1:0]   num_i,
  output logic                       valid_o,
  output qau_side_t                  side_o,
  output logic [3:0][QUO_BITS-1:0]   quo_o
);

  localparam int Steps = QUO_BITS;

  logic                          valid_q [Steps];
  qau_side_t                     side_q  [Steps];
  logic [SQ_BITS-1:0]            den_q   [Steps];
  logic [3:0][REM_BITS-1:0]      rem_q   [Steps];
  logic [3:0][QUO_BITS-1:0]      quo_q   [Steps];

  logic                          cur_valid [Steps];
  qau_side_t                     cur_side  [Steps];
  logic [SQ_BITS-1:0]            cur_den   [Steps];
  logic [3:0][REM_BITS-1:0]      cur_rem   [Steps];
  logic [3:0][QUO_BITS-1:0]      cur_quo   [Steps];
  logic [REM_BITS-1:0]           trial     [Steps];
  logic [3:0]                    take      [Steps];

  // stage inputs
  always_comb begin
    cur_valid[0] = valid_i;
    cur_side[0]  = side_i;
    cur_den[0]   = den_i;
    for (int l = 0; l < 4; l++) begin
      cur_rem[0][l] = REM_BITS'(num_i[l]);
      cur_quo[0][l] = '0;
    end
    for (int k = 1; k < Steps; k++) begin
      cur_valid[k] = valid_q[k-1];
      cur_side[k]  = side_q[k-1];
      cur_den[k]   = den_q[k-1];
      cur_rem[k]   = rem_q[k-1];
      cur_quo[k]   = quo_q[k-1];
    end
  end

  // compare each lane against the shifted divisor
  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      trial[k] = REM_BITS'(cur_den[k]) << (Steps - 1 - k);
      for (int l = 0; l < 4; l++) take[k][l] = cur_rem[k][l] >= trial[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Steps; k++) valid_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < Steps; k++) valid_q[k] <= cur_valid[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Steps; k++) begin
      side_q[k] <= cur_side[k];
      den_q[k]  <= cur_den[k];
      for (int l = 0; l < 4; l++) begin
        if (take[k][l]) begin
          rem_q[k][l] <= cur_rem[k][l] - trial[k];
          quo_q[k][l] <= cur_quo[k][l] | (QUO_BITS'(1) << (Steps - 1 - k));
        end else begin
          rem_q[k][l] <= cur_rem[k][l];
          quo_q[k][l] <= cur_quo[k][l];
        end
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign side_o  = side_q[Steps-1];
  assign quo_o   = quo_q[Steps-1];

  // fixed depth and no stall, so every valid output stems from a valid input
  a_div_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, Steps))
    else $error("divider output without matching input");

endmodule

/* rtl/quaternion_arithmetic_unit.sv */
// quaternion_arithmetic_unit: top level of the fixed-point quaternion unit.
// Depends on qau_pkg, qau_sqrt and qau_div.
//
// Usage:
//   An item (command plus quaternions a and b, signed Q7.24) is taken at each
//   rising edge with start high and busy low. busy is always low: the unit
//   is a fixed-depth pipeline and takes one item in every cycle.
//   Each item gives exactly one result on result_o, marked by result_valid_o
//   for one cycle. Every command takes the same path through the pipeline,
//   so results leave in the order the items came in.
//   The depth is set by the square root (33 stages, one root bit each) and
//   the divider (32 stages, one quotient bit each) plus 7 stages of input
//   capture, products, sums with clipping, divider setup and output.
//   The threshold register (cfg_we_i, cfg_wdata_i) is written at any edge
//   with cfg_we_i high; write it only while no item is in flight.
//   Reset clears all pipeline valid bits and loads the threshold with 17.
//   The receiver cannot stall; results are never held back or repeated.
module quaternion_arithmetic_unit
  import qau_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  qau_in_t             operands_i,
  input  logic                cfg_we_i,
  input  logic [THR_BITS-1:0] cfg_wdata_i,
  output logic                result_valid_o,
  output qau_out_t            result_o
);

  localparam int Latency = 7 + ROOT_BITS + QUO_BITS;

  // threshold register
  logic [THR_BITS-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // stage 0: input capture, scalar of b dropped for the derivative
  logic    v0_q;
  qau_in_t in0_d;
  qau_in_t in0_q;
  qword_t  a0 [4];
  qword_t  b0 [4];

  always_comb begin
    in0_d = operands_i;
    if (operands_i.command == CMD_DER) in0_d.b_w = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else v0_q <= start && !busy;
  end

  always_ff @(posedge clk_i) begin
    in0_q <= in0_d;
  end

  assign a0[0] = in0_q.a_w;
  assign a0[1] = in0_q.a_x;
  assign a0[2] = in0_q.a_y;
  assign a0[3] = in0_q.a_z;
  assign b0[0] = in0_q.b_w;
  assign b0[1] = in0_q.b_x;
  assign b0[2] = in0_q.b_y;
  assign b0[3] = in0_q.b_z;

  // stage 1: all products of a with b and of a with itself
  logic       v1_q;
  logic [2:0] cmd1_q;
  qword_t     a1_q   [4];
  qword_t     vec1_q [3];
  prod_t      pab_q  [4][4];
  prod_t      ww_q, xx_q, yy_q, zz_q, wx_q, wy_q, wz_q, xy_q, xz_q, yz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    cmd1_q <= in0_q.command;
    for (int i = 0; i < 4; i++) begin
      a1_q[i] <= a0[i];
      for (int j = 0; j < 4; j++) pab_q[i][j] <= a0[i] * b0[j];
    end
    for (int j = 0; j < 3; j++) vec1_q[j] <= b0[j+1];
    ww_q <= a0[0] * a0[0];
    xx_q <= a0[1] * a0[1];
    yy_q <= a0[2] * a0[2];
    zz_q <= a0[3] * a0[3];
    wx_q <= a0[0] * a0[1];
    wy_q <= a0[0] * a0[2];
    wz_q <= a0[0] * a0[3];
    xy_q <= a0[1] * a0[2];
    xz_q <= a0[1] * a0[3];
    yz_q <= a0[2] * a0[3];
  end

  // stage 2: hamilton sums, conjugate, rotation matrix and sum of squares
  sum_t               hsum [4];
  qau_sat_t           hsat [4];
  qau_sat_t           csat [3];
  sum_t               msum [9];
  qau_sat_t           msat [9];
  logic               mclip;
  logic               hclip;
  logic [SQ_BITS-1:0] sq2_d;
  qword_t             r2_d [4];
  logic               clip2_d;

  logic               v2_q;
  logic [2:0]         cmd2_q;
  qword_t             a2_q   [4];
  qword_t             vec2_q [3];
  qword_t             m2_q   [9];
  qword_t             r2_q   [4];
  logic               clip2_q;
  logic [SQ_BITS-1:0] sq2_q;

  always_comb begin
    hsum[0] = sum_t'(pab_q[0][0]) - sum_t'(pab_q[1][1]) - sum_t'(pab_q[2][2])
            - sum_t'(pab_q[3][3]);
    hsum[1] = sum_t'(pab_q[0][1]) + sum_t'(pab_q[1][0]) + sum_t'(pab_q[2][3])
            - sum_t'(pab_q[3][2]);
    hsum[2] = sum_t'(pab_q[0][2]) - sum_t'(pab_q[1][3]) + sum_t'(pab_q[2][0])
            + sum_t'(pab_q[3][1]);
    hsum[3] = sum_t'(pab_q[0][3]) + sum_t'(pab_q[1][2]) - sum_t'(pab_q[2][1])
            + sum_t'(pab_q[3][0]);
    hclip = 1'b0;
    for (int i = 0; i < 4; i++) begin
      hsat[i] = sat_word((cmd1_q == CMD_DER) ? (hsum[i] >>> (FRAC_BITS + 1))
                                             : (hsum[i] >>> FRAC_BITS));
      hclip   = hclip | hsat[i].clip;
    end
    for (int i = 0; i < 3; i++) csat[i] = sat_word(-sum_t'(a1_q[i+1]));

    // rotation matrix; off-diagonal entries are doubled products
    msum[0] = sum_t'(ww_q) + sum_t'(xx_q) - sum_t'(yy_q) - sum_t'(zz_q);
    msum[1] = sum_t'(xy_q) - sum_t'(wz_q);
    msum[2] = sum_t'(xz_q) + sum_t'(wy_q);
    msum[3] = sum_t'(xy_q) + sum_t'(wz_q);
    msum[4] = sum_t'(ww_q) - sum_t'(xx_q) + sum_t'(yy_q) - sum_t'(zz_q);
    msum[5] = sum_t'(yz_q) - sum_t'(wx_q);
    msum[6] = sum_t'(xz_q) - sum_t'(wy_q);
    msum[7] = sum_t'(yz_q) + sum_t'(wx_q);
    msum[8] = sum_t'(ww_q) - sum_t'(xx_q) - sum_t'(yy_q) + sum_t'(zz_q);
    mclip = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (i == 0 || i == 4 || i == 8) msat[i] = sat_word(msum[i] >>> FRAC_BITS);
      else msat[i] = sat_word(msum[i] >>> (FRAC_BITS - 1));
      mclip = mclip | msat[i].clip;
    end

    // squares are never negative, so their top bit is dropped
    sq2_d = SQ_BITS'(ww_q[PROD_BITS-2:0]) + SQ_BITS'(xx_q[PROD_BITS-2:0])
          + SQ_BITS'(yy_q[PROD_BITS-2:0]) + SQ_BITS'(zz_q[PROD_BITS-2:0]);

    for (int i = 0; i < 4; i++) r2_d[i] = '0;
    clip2_d = 1'b0;
    case (qau_cmd_e'(cmd1_q))
      CMD_MUL, CMD_DER: begin
        for (int i = 0; i < 4; i++) r2_d[i] = hsat[i].val;
        clip2_d = hclip;
      end
      CMD_ROT: begin
        clip2_d = mclip;
      end
      CMD_CONJ: begin
        r2_d[0] = a1_q[0];
        for (int i = 0; i < 3; i++) r2_d[i+1] = csat[i].val;
        clip2_d = csat[0].clip | csat[1].clip | csat[2].clip;
      end
      default: begin
        clip2_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    cmd2_q  <= cmd1_q;
    clip2_q <= clip2_d;
    sq2_q   <= sq2_d;
    for (int i = 0; i < 4; i++) begin
      a2_q[i] <= a1_q[i];
      r2_q[i] <= r2_d[i];
    end
    for (int j = 0; j < 3; j++) vec2_q[j] <= vec1_q[j];
    for (int i = 0; i < 9; i++) m2_q[i] <= msat[i].val;
  end

  // stage 3: matrix times vector products
  logic               v3_q;
  logic [2:0]         cmd3_q;
  qword_t             a3_q  [4];
  qword_t             r3_q  [4];
  logic               clip3_q;
  logic [SQ_BITS-1:0] sq3_q;
  prod_t              pm3_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    cmd3_q  <= cmd2_q;
    clip3_q <= clip2_q;
    sq3_q   <= sq2_q;
    for (int i = 0; i < 4; i++) begin
      a3_q[i] <= a2_q[i];
      r3_q[i] <= r2_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) pm3_q[i][j] <= m2_q[3*i+j] * vec2_q[j];
    end
  end

  // stage 4: rotated vector sums, item state packed for the long pipes
  sum_t               acc  [3];
  qau_sat_t           rsat [3];
  qau_side_t          side4_d;
  logic               v4_q;
  qau_side_t          side4_q;
  logic [SQ_BITS-1:0] sq4_q;

  always_comb begin
    side4_d         = '0;
    side4_d.command = cmd3_q;
    side4_d.clip    = clip3_q;
    for (int i = 0; i < 4; i++) begin
      side4_d.a[i] = a3_q[i];
      side4_d.r[i] = r3_q[i];
    end
    for (int i = 0; i < 3; i++) begin
      acc[i]  = sum_t'(pm3_q[i][0]) + sum_t'(pm3_q[i][1]) + sum_t'(pm3_q[i][2]);
      rsat[i] = sat_word(acc[i] >>> FRAC_BITS);
    end
    if (cmd3_q == CMD_ROT) begin
      side4_d.r[0] = '0;
      for (int i = 0; i < 3; i++) side4_d.r[i+1] = rsat[i].val;
      side4_d.clip = clip3_q | rsat[0].clip | rsat[1].clip | rsat[2].clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    side4_q <= side4_d;
    sq4_q   <= sq3_q;
  end

  // square root of the sum of squares
  logic                 sq_valid;
  qau_side_t            sq_side;
  logic [SQ_BITS-1:0]   sq_rad;
  logic [ROOT_BITS-1:0] sq_root;

  qau_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v4_q),
    .side_i     (side4_q),
    .radicand_i (sq4_q),
    .valid_o    (sq_valid),
    .side_o     (sq_side),
    .radicand_o (sq_rad),
    .root_o     (sq_root)
  );

  // stage 5: magnitude result, zero and threshold test and divider setup
  logic                     is_norm;
  logic                     is_inv;
  logic [WORD_BITS-1:0]     amag [4];
  sum_t                     root_ext;
  qau_sat_t                 magsat;
  qau_side_t                side5_d;
  logic [SQ_BITS-1:0]       den5_d;
  logic [3:0][NUM_BITS-1:0] num5_d;

  logic                     v5_q;
  qau_side_t                side5_q;
  logic [SQ_BITS-1:0]       den5_q;
  logic [3:0][NUM_BITS-1:0] num5_q;

  always_comb begin
    is_norm  = sq_side.command == CMD_NORM;
    is_inv   = sq_side.command == CMD_INV;
    side5_d  = sq_side;
    den5_d   = is_norm ? SQ_BITS'(sq_root) : sq_rad;
    root_ext = SUM_BITS'(sq_root);
    magsat   = sat_word(root_ext);
    for (int l = 0; l < 4; l++) begin
      amag[l]   = sq_side.a[l][WORD_BITS-1] ? (~sq_side.a[l] + 1'b1) : sq_side.a[l];
      num5_d[l] = is_norm ? (NUM_BITS'(amag[l]) << FRAC_BITS)
                          : (NUM_BITS'(amag[l]) << (2 * FRAC_BITS));
      side5_d.neg[l] = sq_side.a[l][WORD_BITS-1] ^ (is_inv && (l != 0));
      side5_d.ovf[l] = REM_BITS'(num5_d[l]) >= (REM_BITS'(den5_d) << QUO_BITS);
    end
    side5_d.deg = (is_norm && ((sq_root == '0) || (sq_root < ROOT_BITS'(thr_q))))
               || (is_inv && ((sq_rad == '0) || ((sq_rad >> FRAC_BITS) < SQ_BITS'(thr_q))));
    if (sq_side.command == CMD_MAG) begin
      side5_d.r[0] = magsat.val;
      side5_d.clip = magsat.clip;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= sq_valid;
  end

  always_ff @(posedge clk_i) begin
    side5_q <= side5_d;
    den5_q  <= den5_d;
    num5_q  <= num5_d;
  end

  // component divides for normalize and inverse
  logic                     dv_valid;
  qau_side_t                dv_side;
  logic [3:0][QUO_BITS-1:0] dv_quo;

  qau_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .side_i  (side5_q),
    .den_i   (den5_q),
    .num_i   (num5_q),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quo_o   (dv_quo)
  );

  // stage 6: sign, clip and identity fallback, then the output register
  sum_t     one_val;
  qau_sat_t onesat;
  sum_t     qval [4];
  qau_sat_t lsat [4];
  qword_t   fr   [4];
  logic     fclip;
  logic     fdeg;
  qau_out_t out_d;
  logic     out_valid_q;
  qau_out_t out_q;

  always_comb begin
    one_val = sum_t'(1) << FRAC_BITS;
    onesat  = sat_word(one_val);
    for (int l = 0; l < 4; l++) begin
      qval[l] = {{(SUM_BITS-QUO_BITS){1'b0}}, dv_quo[l]};
      if (dv_side.neg[l]) qval[l] = -qval[l];
      lsat[l] = sat_word(qval[l]);
    end
    for (int l = 0; l < 4; l++) fr[l] = dv_side.r[l];
    fclip = dv_side.clip;
    fdeg  = 1'b0;
    if (dv_side.command == CMD_NORM || dv_side.command == CMD_INV) begin
      if (dv_side.deg) begin
        fr[0] = onesat.val;
        for (int l = 1; l < 4; l++) fr[l] = '0;
        fclip = onesat.clip;
        fdeg  = 1'b1;
      end else begin
        fclip = 1'b0;
        for (int l = 0; l < 4; l++) begin
          if (dv_side.ovf[l]) begin
            fr[l] = dv_side.neg[l] ? QWORD_MIN : QWORD_MAX;
            fclip = 1'b1;
          end else begin
            fr[l] = lsat[l].val;
            fclip = fclip | lsat[l].clip;
          end
        end
      end
    end
    out_d.r_w        = fr[0];
    out_d.r_x        = fr[1];
    out_d.r_y        = fr[2];
    out_d.r_z        = fr[3];
    out_d.degenerate = fdeg;
    out_d.saturated  = fclip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= dv_valid;
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  // every result traces back to an accepted item a fixed depth earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, Latency))
    else $error("result without accepted item");

  // identity fallback leaves the vector part clear
  a_deg_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.degenerate |->
      result_o.r_x == '0 && result_o.r_y == '0 && result_o.r_z == '0)
    else $error("degenerate result is not identity");

endmodule
